@@ sv/spq_pkg.sv @@
package spq_pkg;

   localparam int CAPACITY = 16;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int VALUE_W  = 8;
   localparam int KIND_W   = 2;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [KIND_W-1:0]  kind;
   } entry_type;

   // shift control broadcast to every cell
   typedef struct packed {
      logic ins_en;
      logic pop_en;
   } shift_ctrl_type;

endpackage

@@ sv/spq_cell.sv @@
module spq_cell (
   input  logic                    clock,
   input  spq_pkg::shift_ctrl_type ctrl,
   input  spq_pkg::entry_type      new_entry,
   input  logic                    occupied,
   input  logic                    left_keep,
   input  spq_pkg::entry_type      left_entry,
   input  spq_pkg::entry_type      right_entry,
   output logic                    keep,
   output spq_pkg::entry_type      entry
);

   spq_pkg::entry_type entry_ff;
   spq_pkg::entry_type entry_in;

   // stays put when it is occupied and its key beats the new one
   assign keep = occupied && (entry_ff.value > new_entry.value);

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.ins_en) begin
         if (keep) begin
            entry_in = entry_ff;
         end else if (left_keep) begin
            entry_in = new_entry;
         end else begin
            entry_in = left_entry;
         end
      end else if (ctrl.pop_en) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

@@ sv/sorted_priority_queue_core.sv @@
// channel   | ports                                    | handshake
// ----------+------------------------------------------+--------------------------------
// request   | req_op, req_card_value, req_card_kind    | taken when start & !busy
// response  | rsp_taken_*, rsp_insert_rejected,        | rsp_valid high for one cycle,
//           | rsp_entry_count                          | no backpressure
//
// one word per cycle: every cell compares its key with the new key at once,
// so an insert or a remove finishes in the cycle it is taken and busy stays low.
// the response is registered and appears in the cycle after the request is taken.
// reset clears the entry count and the response strobe; cell contents stay as is.
// the receiver cannot stall, so nothing is held back on the response side.
module sorted_priority_queue_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_op,
   input  logic [spq_pkg::VALUE_W-1:0] req_card_value,
   input  logic [spq_pkg::KIND_W-1:0]  req_card_kind,
   output logic                        rsp_valid,
   output logic                        rsp_taken_valid,
   output logic [spq_pkg::VALUE_W-1:0] rsp_taken_value,
   output logic [spq_pkg::KIND_W-1:0]  rsp_taken_kind,
   output logic                        rsp_insert_rejected,
   output logic [spq_pkg::COUNT_W-1:0] rsp_entry_count
);

   logic                        accept;
   logic                        is_full;
   logic                        is_empty;
   spq_pkg::shift_ctrl_type     ctrl;
   spq_pkg::entry_type          new_entry;

   logic [spq_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                        rsp_valid_ff;
   logic                        taken_valid_ff, taken_valid_in;
   spq_pkg::entry_type          taken_ff, taken_in;
   logic                        rejected_ff, rejected_in;

   // per-cell links: keep flags and entries of the chain
   logic [spq_pkg::CAPACITY-1:0] keep_vec;
   spq_pkg::entry_type           cell_entry [spq_pkg::CAPACITY];

   assign busy      = 1'b0;
   assign accept    = start && !busy;
   assign is_full   = (count_ff == spq_pkg::COUNT_W'(spq_pkg::CAPACITY));
   assign is_empty  = (count_ff == '0);
   assign new_entry = '{value: req_card_value, kind: req_card_kind};

   always_comb begin
      ctrl.ins_en    = accept && (req_op == spq_pkg::OP_INSERT) && !is_full;
      ctrl.pop_en    = accept && (req_op == spq_pkg::OP_REMOVE) && !is_empty;
      count_in       = count_ff;
      taken_valid_in = 1'b0;
      taken_in       = '0;
      rejected_in    = accept && (req_op == spq_pkg::OP_INSERT) && is_full;
      if (ctrl.ins_en) begin
         count_in = count_ff + 1'b1;
      end else if (ctrl.pop_en) begin
         count_in       = count_ff - 1'b1;
         taken_valid_in = 1'b1;
         taken_in       = cell_entry[0];   // head sits in cell zero
      end
   end

   // the chain: cell zero holds the head, larger keys toward the front
   for (genvar i = 0; i < spq_pkg::CAPACITY; i++) begin : g_cell
      logic               occ;
      logic               lkeep;
      spq_pkg::entry_type lentry;
      spq_pkg::entry_type rentry;

      assign occ = (spq_pkg::COUNT_W'(i) < count_ff);

      if (i == 0) begin : g_head
         // nothing ahead of the head: it takes the new word if it yields
         assign lkeep  = 1'b1;
         assign lentry = new_entry;
      end else begin : g_mid
         assign lkeep  = keep_vec[i-1];
         assign lentry = cell_entry[i-1];
      end

      if (i == spq_pkg::CAPACITY - 1) begin : g_tail
         // tail content after a pop lies past the count and is never read
         assign rentry = cell_entry[i];
      end else begin : g_body
         assign rentry = cell_entry[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .new_entry   (new_entry),
         .occupied    (occ),
         .left_keep   (lkeep),
         .left_entry  (lentry),
         .right_entry (rentry),
         .keep        (keep_vec[i]),
         .entry       (cell_entry[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
   end

   // response payload, no reset needed
   always_ff @(posedge clock) begin
      taken_valid_ff <= taken_valid_in;
      taken_ff       <= taken_in;
      rejected_ff    <= rejected_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_taken_valid     = taken_valid_ff;
   assign rsp_taken_value     = taken_ff.value;
   assign rsp_taken_kind      = taken_ff.kind;
   assign rsp_insert_rejected = rejected_ff;
   assign rsp_entry_count     = count_ff;

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

// checks sorted_priority_queue_core against a cycle-free model of the sorted list
// one word is taken per start & !busy edge and one response is expected per word
module testbench;

   localparam int RANDOM_WORDS = 950;
   localparam int PHASES       = 10;
   localparam int LIMIT_CYCLES = 200000;
   localparam int SETTLE       = 6;

   // one expected response, same field order as the response ports
   typedef struct packed {
      logic                        taken_valid;
      logic [spq_pkg::VALUE_W-1:0] taken_value;
      logic [spq_pkg::KIND_W-1:0]  taken_kind;
      logic                        insert_rejected;
      logic [spq_pkg::COUNT_W-1:0] entry_count;
   } queue_response_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic                        req_op = spq_pkg::OP_INSERT;
   logic [spq_pkg::VALUE_W-1:0] req_card_value = '0;
   logic [spq_pkg::KIND_W-1:0]  req_card_kind = '0;
   logic                        rsp_valid;
   logic                        rsp_taken_valid;
   logic [spq_pkg::VALUE_W-1:0] rsp_taken_value;
   logic [spq_pkg::KIND_W-1:0]  rsp_taken_kind;
   logic                        rsp_insert_rejected;
   logic [spq_pkg::COUNT_W-1:0] rsp_entry_count;

   // private copy of the sorted list, head at slot 0
   logic [spq_pkg::VALUE_W-1:0] list_values[spq_pkg::CAPACITY];
   logic [spq_pkg::KIND_W-1:0]  list_kinds[spq_pkg::CAPACITY];
   int unsigned                 list_count = 0;

   queue_response_type          outstanding_responses[$];

   // bookkeeping for the closing summary
   int unsigned words_sent = 0;
   int unsigned inserts_sent = 0;
   int unsigned inserts_refused = 0;
   int unsigned removes_sent = 0;
   int unsigned removes_on_empty = 0;
   int unsigned peak_count = 0;
   int unsigned responses_checked = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   bit          idling_on = 1'b1;

   sorted_priority_queue_core DUT (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_op              (req_op),
      .req_card_value      (req_card_value),
      .req_card_kind       (req_card_kind),
      .rsp_valid           (rsp_valid),
      .rsp_taken_valid     (rsp_taken_valid),
      .rsp_taken_value     (rsp_taken_value),
      .rsp_taken_kind      (rsp_taken_kind),
      .rsp_insert_rejected (rsp_insert_rejected),
      .rsp_entry_count     (rsp_entry_count)
   );

   // 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // watchdog: a hung handshake or a lost response ends here
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, outstanding_responses.size());
         $display("testbench failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at cycle %0d, response %0d: %s got %0d expected %0d",
               cycle_count, responses_checked, what, got, want);
      mismatch_count++;
   endtask

   // applies one word to the list copy and returns the response it must produce
   function automatic queue_response_type apply_word(
      input logic                        op,
      input logic [spq_pkg::VALUE_W-1:0] value,
      input logic [spq_pkg::KIND_W-1:0]  kind);
      queue_response_type rsp;
      int unsigned        pos;
      int unsigned        i;
      rsp = '0;
      if (op == spq_pkg::OP_INSERT) begin
         inserts_sent++;
         if (list_count >= spq_pkg::CAPACITY) begin
            // full list: refused, nothing moves
            rsp.insert_rejected = 1'b1;
            inserts_refused++;
         end else begin
            // go past every strictly larger key, so the new word leads its equals
            pos = 0;
            while (pos < list_count && list_values[pos] > value)
               pos++;
            for (i = list_count; i > pos; i--) begin
               list_values[i] = list_values[i-1];
               list_kinds[i]  = list_kinds[i-1];
            end
            list_values[pos] = value;
            list_kinds[pos]  = kind;
            list_count++;
         end
      end else begin
         removes_sent++;
         if (list_count == 0) begin
            // empty list: taken fields stay zero
            removes_on_empty++;
         end else begin
            rsp.taken_valid = 1'b1;
            rsp.taken_value = list_values[0];
            rsp.taken_kind  = list_kinds[0];
            for (i = 1; i < list_count; i++) begin
               list_values[i-1] = list_values[i];
               list_kinds[i-1]  = list_kinds[i];
            end
            list_count--;
         end
      end
      rsp.entry_count = list_count[spq_pkg::COUNT_W-1:0];
      if (list_count > peak_count)
         peak_count = list_count;
      return rsp;
   endfunction

   // drives one word from the falling edge and holds it until it is taken
   task automatic send_word(input logic op, input logic [spq_pkg::VALUE_W-1:0] value,
                            input logic [spq_pkg::KIND_W-1:0] kind);
      @(negedge clock);
      start          <= 1'b1;
      req_op         <= op;
      req_card_value <= value;
      req_card_kind  <= kind;
      forever begin
         @(posedge clock);
         if (!busy)
            break;
      end
      outstanding_responses.push_back(apply_word(op, value, kind));
      words_sent++;
   endtask

   // start low for a number of cycles; the request fields carry noise meanwhile
   task automatic idle_cycles(input int unsigned cycles);
      repeat (cycles) begin
         @(negedge clock);
         start          <= 1'b0;
         req_op         <= 1'($urandom_range(0, 1));
         req_card_value <= 8'($urandom);
         req_card_kind  <= 2'($urandom_range(0, 3));
      end
   endtask

   // occasional burst of idle cycles between words
   task automatic maybe_idle();
      if (idling_on && $urandom_range(0, 5) == 0)
         idle_cycles($urandom_range(1, 14));
   endtask

   // holds off the sender until every expected response has been checked
   task automatic wait_for_drain();
      idle_cycles(1);
      while (outstanding_responses.size() != 0)
         @(posedge clock);
   endtask

   // response checker: the oldest expectation must match field by field
   always @(posedge clock) begin : check_responses
      queue_response_type want;
      if (!reset && rsp_valid) begin
         if (outstanding_responses.size() == 0) begin
            report_mismatch("response with no word outstanding, entry_count",
                            rsp_entry_count, -1);
         end else begin
            want = outstanding_responses.pop_front();
            if (rsp_taken_valid !== want.taken_valid)
               report_mismatch("taken_valid", rsp_taken_valid, want.taken_valid);
            if (rsp_taken_value !== want.taken_value)
               report_mismatch("taken_value", rsp_taken_value, want.taken_value);
            if (rsp_taken_kind !== want.taken_kind)
               report_mismatch("taken_kind", rsp_taken_kind, want.taken_kind);
            if (rsp_insert_rejected !== want.insert_rejected)
               report_mismatch("insert_rejected", rsp_insert_rejected,
                               want.insert_rejected);
            if (rsp_entry_count !== want.entry_count)
               report_mismatch("entry_count", rsp_entry_count, want.entry_count);
         end
         responses_checked++;
      end
   end

   // synchronous reset, applied only once
   task automatic apply_reset();
      reset <= 1'b1;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      list_count = 0;
   endtask

   // empty list handling: remove with nothing stored, then a first insert
   task automatic test_empty_list();
      send_word(spq_pkg::OP_REMOVE, 8'hFF, 2'd3);   // ignored fields set to their maximum
      send_word(spq_pkg::OP_INSERT, 8'h00, 2'd0);   // insert into an empty list
   endtask

   // ordering at the key extremes, tag three, and newest-first among equal keys
   task automatic test_ordering();
      send_word(spq_pkg::OP_INSERT, 8'hFF, 2'd3);   // lands at the head
      send_word(spq_pkg::OP_INSERT, 8'h00, 2'd2);   // ties the stored zero, goes ahead of it
      repeat (3) send_word(spq_pkg::OP_REMOVE, 8'h00, 2'd0);
      send_word(spq_pkg::OP_REMOVE, 8'hA5, 2'd1);   // remove on an empty list again
   endtask

   // fill every slot back to back, then two inserts that must be refused
   task automatic test_full_list();
      logic [spq_pkg::VALUE_W-1:0] fill_keys[spq_pkg::CAPACITY];
      int                          i;
      fill_keys = '{8'd77, 8'd200, 8'd77, 8'd3, 8'd255, 8'd128, 8'd0, 8'd128,
                    8'd77, 8'd19, 8'd255, 8'd0, 8'd64, 8'd128, 8'd200, 8'd1};
      for (i = 0; i < spq_pkg::CAPACITY; i++)
         send_word(spq_pkg::OP_INSERT, fill_keys[i], 2'(i % 4));
      send_word(spq_pkg::OP_INSERT, 8'hFF, 2'd1);
      send_word(spq_pkg::OP_INSERT, 8'h00, 2'd2);
   endtask

   // picks a key: full range, a tight cluster for ties, the extremes, or mid range
   function automatic logic [spq_pkg::VALUE_W-1:0] pick_key();
      case ($urandom_range(0, 3))
         0: return 8'($urandom);
         1: return 8'($urandom_range(0, 3));
         2: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
         default: return 8'($urandom_range(120, 136));
      endcase
   endfunction

   // random traffic in phases that lean toward filling, draining or neither
   task automatic test_random_traffic();
      int          phase;
      int          n;
      int unsigned insert_weight;
      logic        op;
      for (phase = 0; phase < PHASES; phase++) begin
         // drain first, since the previous test left the list full
         case ((phase + 1) % 3)
            0: insert_weight = 85;
            1: insert_weight = 15;
            default: insert_weight = 50;
         endcase
         // a stretch without gaps mid-run, and none in the closing phases
         idling_on = (phase != 3) && (phase < PHASES - 2);
         for (n = 0; n < RANDOM_WORDS / PHASES; n++) begin
            op = ($urandom_range(1, 100) <= insert_weight) ? spq_pkg::OP_INSERT
                                                            : spq_pkg::OP_REMOVE;
            send_word(op, pick_key(), 2'($urandom_range(0, 3)));
            maybe_idle();
         end
         // sender pause until every response is in
         if (phase == 4 || $urandom_range(0, 3) == 0)
            wait_for_drain();
      end
   endtask

   initial begin
      apply_reset();
      test_empty_list();
      test_ordering();
      test_full_list();
      test_random_traffic();
      idle_cycles(1);
      while (outstanding_responses.size() != 0)
         @(posedge clock);
      // the response is registered, so the settle wait also catches a stray strobe
      repeat (SETTLE) @(posedge clock);
      if (outstanding_responses.size() != 0)
         report_mismatch("responses never seen", 0, outstanding_responses.size());
      $display("sent %0d words: %0d inserts (%0d refused on a full list),",
               words_sent, inserts_sent, inserts_refused);
      $display("%0d removes (%0d on an empty list), checked %0d responses, peak count %0d",
               removes_sent, removes_on_empty, responses_checked, peak_count);
      if (mismatch_count == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule

@@ files.f @@
sv/spq_pkg.sv
sv/spq_cell.sv
sv/sorted_priority_queue_core.sv
verif/testbench.sv
